// ===== design/score_heatmap_colorizer_core_defines.svh =====
// assertion macros for the score heatmap colorizer
`ifndef SCORE_HEATMAP_COLORIZER_CORE_DEFINES_SVH
`define SCORE_HEATMAP_COLORIZER_CORE_DEFINES_SVH
`ifndef SYNTH
`define SHC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("shc assertion failed");
`define SHC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shc assertion failed");
`else
`define SHC_ASSERT(lbl, prop)
`define SHC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== design/shc_pkg.sv =====
// types, constants and colour table of the score heatmap colorizer
package shc_pkg;

    localparam int LEVEL_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int REM_W     = 60;
    localparam int DEN_W     = 31;
    localparam int QUO_W     = 29;
    localparam int POS_FRAC  = 24;
    localparam int MIX_W     = 26;
    localparam int SQIN_W    = 19;
    localparam int SQOUT_W   = 10;

    localparam logic [0:0] REG_GOOD_LEVEL = 1'b0;
    localparam logic [0:0] REG_BAD_LEVEL  = 1'b1;

    localparam logic [LEVEL_W-1:0] GOOD_RESET = 24'd65536;
    localparam logic [LEVEL_W-1:0] BAD_RESET  = 24'd98304;

    localparam logic [QUO_W-1:0] POS_MAX = 29'd10 << POS_FRAC;

    typedef logic [1:0] half_t;

    // colour table in halves, channel 0 red, 1 green, 2 blue
    function automatic half_t color_half(input logic [3:0] ix, input logic [1:0] ch);
        logic [5:0] rgb;
        begin
            unique case (ix)
                4'd0:    rgb = {2'd0, 2'd0, 2'd0};
                4'd1:    rgb = {2'd2, 2'd0, 2'd0};
                4'd2:    rgb = {2'd2, 2'd2, 2'd0};
                4'd3:    rgb = {2'd0, 2'd2, 2'd0};
                4'd4:    rgb = {2'd0, 2'd2, 2'd2};
                4'd5:    rgb = {2'd0, 2'd0, 2'd2};
                4'd6:    rgb = {2'd2, 2'd0, 2'd2};
                4'd7:    rgb = {2'd2, 2'd1, 2'd1};
                4'd8:    rgb = {2'd1, 2'd1, 2'd2};
                4'd9:    rgb = {2'd1, 2'd2, 2'd2};
                default: rgb = {2'd2, 2'd2, 2'd2};
            endcase
            case (ch)
                2'd0:    color_half = rgb[1:0];
                2'd1:    color_half = rgb[3:2];
                default: color_half = rgb[5:4];
            endcase
        end
    endfunction

endpackage

// ===== design/score_heatmap_colorizer_core.sv =====
// score heatmap colorizer: one rgb colour per distance score
// One colour item leaves for every score item taken, in order; a new score
// can enter in every cycle while the output is not stalled. The pipeline
// holds a 29-step restoring divider (one quotient bit per stage) forming the
// scaled position, then the colour interpolation, and a 10-step square root
// per channel (one result bit per stage). The whole pipeline advances
// together and holds while a finished colour waits at the output. good_level
// and bad_level are written through the cfg port and take effect for scores
// entering afterwards; write them only while the pipeline is empty.
`include "score_heatmap_colorizer_core_defines.svh"

module score_heatmap_colorizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // score
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red, green, blue
);

    localparam int DIV_STEPS = shc_pkg::QUO_W;
    localparam int SQ_STEPS  = shc_pkg::SQOUT_W;

    logic en;
    logic [shc_pkg::LEVEL_W-1:0] good_reg;
    logic [shc_pkg::LEVEL_W-1:0] bad_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_reg <= shc_pkg::GOOD_RESET;
            bad_reg  <= shc_pkg::BAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                shc_pkg::REG_GOOD_LEVEL: good_reg <= cfg_data;
                shc_pkg::REG_BAD_LEVEL:  bad_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // segment select and division operands
    logic [shc_pkg::REM_W-1:0] num_next;
    logic [shc_pkg::DEN_W-1:0] den_next;
    logic [29:0] s33;
    logic [23:0] diff, ofs, sb;
    logic [25:0] sum2;
    logic [31:0] p2;
    logic [35:0] p3;

    always_comb
    begin
        s33  = 30'(s_tdata) * 30'd33;
        diff = bad_reg - good_reg;
        ofs  = s_tdata - good_reg;
        sb   = s_tdata - bad_reg;
        sum2 = {1'b0, diff, 1'b0} + 26'(ofs);
        p2   = 32'(sum2) * 32'd33;
        p3   = 36'(bad_reg) * 36'd594 + 36'(sb) * 36'd55;
        if (s_tdata < good_reg)
        begin
            num_next = {6'd0, s33, 24'd0};
            den_next = 31'(good_reg) * 31'd10;
        end
        else if (s_tdata < bad_reg)
        begin
            num_next = {5'd0, p2, 23'd0};
            den_next = 31'(diff) * 31'd10;
        end
        else
        begin
            num_next = {p3, 24'd0};
            den_next = 31'(bad_reg) * 31'd120;
        end
    end

    logic                      a_v_reg;
    logic [shc_pkg::REM_W-1:0] a_num_reg;
    logic [shc_pkg::DEN_W-1:0] a_den_reg;

    // divider
    logic                      div_v_reg   [0:DIV_STEPS];
    logic                      div_sat_reg [0:DIV_STEPS];
    logic [shc_pkg::REM_W-1:0] div_rem_reg [0:DIV_STEPS];
    logic [shc_pkg::DEN_W-1:0] div_den_reg [0:DIV_STEPS];
    logic [shc_pkg::QUO_W-1:0] div_q_reg   [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            div_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg      <= s_tvalid;
            div_v_reg[0] <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_num_reg      <= num_next;
            a_den_reg      <= den_next;
            div_sat_reg[0] <= a_num_reg >= {a_den_reg, 29'd0};
            div_rem_reg[0] <= a_num_reg;
            div_den_reg[0] <= a_den_reg;
            div_q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int BIT = DIV_STEPS - 1 - j;
        logic [shc_pkg::REM_W-1:0] sub;
        assign sub = {29'd0, div_den_reg[j]} << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_v_reg[j+1] <= 1'b0;
            else if (en)
                div_v_reg[j+1] <= div_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_sat_reg[j+1] <= div_sat_reg[j];
                div_den_reg[j+1] <= div_den_reg[j];
                if (div_rem_reg[j] >= sub)
                begin
                    div_rem_reg[j+1] <= div_rem_reg[j] - sub;
                    div_q_reg[j+1]   <= div_q_reg[j] | (29'd1 << BIT);
                end
                else
                begin
                    div_rem_reg[j+1] <= div_rem_reg[j];
                    div_q_reg[j+1]   <= div_q_reg[j];
                end
            end
        end
    end

    // clamp and interpolate
    logic [shc_pkg::QUO_W-1:0] pos;
    logic [3:0]                ix;
    logic [23:0]               mix;
    logic [24:0]               inv;
    logic [shc_pkg::MIX_W-1:0] n_next [0:2];

    always_comb
    begin
        if (div_sat_reg[DIV_STEPS] || div_q_reg[DIV_STEPS] > shc_pkg::POS_MAX)
            pos = shc_pkg::POS_MAX;
        else
            pos = div_q_reg[DIV_STEPS];
        ix  = pos[27:24];
        mix = pos[23:0];
        inv = 25'd1 << shc_pkg::POS_FRAC;
        inv = inv - 25'(mix);
        for (int c = 0; c < 3; c++)
        begin
            n_next[c] = 26'(mix) * 26'(shc_pkg::color_half(ix + 4'd1, 2'(c)))
                      + 26'(inv) * 26'(shc_pkg::color_half(ix, 2'(c)));
        end
    end

    logic                        c_v_reg;
    logic [shc_pkg::MIX_W-1:0]   n_reg [0:2];
    logic                        sq_v_reg [0:SQ_STEPS];
    logic [shc_pkg::SQIN_W-1:0]  sq_x_reg [0:SQ_STEPS][0:2];
    logic [shc_pkg::SQOUT_W-1:0] sq_r_reg [0:SQ_STEPS][0:2];
    logic [43:0]                 prod [0:2];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            prod[c] = 44'(n_reg[c]) * 44'd260100;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg     <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            c_v_reg     <= div_v_reg[DIV_STEPS];
            sq_v_reg[0] <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[c]       <= n_next[c];
                sq_x_reg[0][c] <= prod[c][43:25];
                sq_r_reg[0][c] <= '0;
            end
        end
    end

    // integer square root, one bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sq
        localparam int BIT = SQ_STEPS - 1 - j;
        logic [shc_pkg::SQOUT_W-1:0] trial [0:2];
        logic [19:0]                 tsq   [0:2];

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                trial[c] = sq_r_reg[j][c] | (10'd1 << BIT);
                tsq[c]   = 20'(trial[c]) * 20'(trial[c]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else if (en)
                sq_v_reg[j+1] <= sq_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    sq_x_reg[j+1][c] <= sq_x_reg[j][c];
                    if (tsq[c] <= 20'(sq_x_reg[j][c]))
                        sq_r_reg[j+1][c] <= trial[c];
                    else
                        sq_r_reg[j+1][c] <= sq_r_reg[j][c];
                end
            end
        end
    end

    // output register
    logic                        out_v_reg;
    logic [23:0]                 out_data_reg;
    logic [23:0]                 out_data_next;
    logic [shc_pkg::SQOUT_W:0]   rnd [0:2];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rnd[c] = 11'(sq_r_reg[SQ_STEPS][c]) + 11'd1;
            out_data_next[c*8 +: 8] = rnd[c][8:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= sq_v_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;

    `SHC_ASSERT(a_stall_rule, s_tready == (!m_tvalid || m_tready))
    `SHC_ASSERT_IMPL(a_div_rem, div_v_reg[DIV_STEPS] && !div_sat_reg[DIV_STEPS], div_rem_reg[DIV_STEPS] < {29'd0, div_den_reg[DIV_STEPS]})
    `SHC_ASSERT_IMPL(a_sqrt_range, sq_v_reg[SQ_STEPS], sq_r_reg[SQ_STEPS][0] <= 10'd510 && sq_r_reg[SQ_STEPS][1] <= 10'd510 && sq_r_reg[SQ_STEPS][2] <= 10'd510)

endmodule

// ===== dv/shc_checker.sv =====
// checker for the score heatmap colorizer: colour predictor and scoreboard
`timescale 1ns / 1ps

module shc_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    localparam logic [63:0] ONE_POS = 64'd1 << shc_pkg::POS_FRAC;

    logic [23:0] good_lvl;
    logic [23:0] bad_lvl;
    logic [23:0] colour_q[$];

    // table in halves, index by entry, channel 0 red
    function automatic logic [1:0] tab_half(input int ix, input int ch);
        logic [5:0] t [12];
        logic [5:0] e;
        t = '{6'h00, 6'h02, 6'h0a, 6'h08, 6'h28, 6'h20,
              6'h22, 6'h16, 6'h25, 6'h29, 6'h2a, 6'h2a};
        e = t[ix];
        return ch == 0 ? e[5:4] : (ch == 1 ? e[3:2] : e[1:0]);
    endfunction

    function automatic logic [63:0] heat_position(input logic [63:0] s);
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] g;
        logic [63:0] b;
        g = good_lvl;
        b = bad_lvl;
        if (s < g)
            t = ((s * 33) << shc_pkg::POS_FRAC) / (10 * g);
        else if (s < b)
        begin
            d = b - g;
            e = s - g;
            t = (33 * (ONE_POS >> 1) * (2 * d + e)) / (10 * d);
        end
        else if (b == 0)
            t = 10 * ONE_POS;
        else
            t = ((594 * b + 55 * (s - b)) << shc_pkg::POS_FRAC) / (120 * b);
        if (t > 10 * ONE_POS)
            t = 10 * ONE_POS;
        return t;
    endfunction

    function automatic logic [7:0] sqrt_channel(input logic [63:0] n);
        logic [63:0] odd;
        logic [7:0] c;
        c = 8'd0;
        for (int k = 1; k <= 255; k++)
        begin
            odd = 64'(2 * k - 1);
            if (((odd * odd) << (shc_pkg::POS_FRAC + 1)) <= 64'd260100 * n)
                c = 8'(k);
            else
                break;
        end
        return c;
    endfunction

    function automatic logic [23:0] heat_colour(input logic [23:0] score);
        logic [63:0] t;
        logic [63:0] mix;
        logic [63:0] n;
        logic [23:0] rgb;
        int ix;
        t = heat_position({40'd0, score});
        ix = int'(t >> shc_pkg::POS_FRAC);
        if (ix > 10)
            ix = 10;
        mix = t & (ONE_POS - 1);
        for (int ch = 0; ch < 3; ch++)
        begin
            n = mix * tab_half(ix + 1, ch) + (ONE_POS - mix) * tab_half(ix, ch);
            rgb[ch*8 +: 8] = sqrt_channel(n);
        end
        return rgb;
    endfunction

    assign pending = colour_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            good_lvl = shc_pkg::GOOD_RESET;
            bad_lvl = shc_pkg::BAD_RESET;
            colour_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (colour_q.size() == 0)
                begin
                    $error("unexpected colour item %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = colour_q.pop_front();
                    if (want[7:0] !== m_tdata[7:0])
                    begin
                        $error("red expected %0d actual %0d", want[7:0], m_tdata[7:0]);
                        fail_count++;
                    end
                    if (want[15:8] !== m_tdata[15:8])
                    begin
                        $error("green expected %0d actual %0d", want[15:8], m_tdata[15:8]);
                        fail_count++;
                    end
                    if (want[23:16] !== m_tdata[23:16])
                    begin
                        $error("blue expected %0d actual %0d", want[23:16], m_tdata[23:16]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                colour_q = {colour_q, heat_colour(s_tdata)};
            if (cfg_we)
            begin
                if (cfg_index == shc_pkg::REG_GOOD_LEVEL)
                    good_lvl = cfg_data;
                else if (cfg_index == shc_pkg::REG_BAD_LEVEL)
                    bad_lvl = cfg_data;
            end
        end
    end
endmodule

// ===== dv/tb.sv =====
// testbench top for the score heatmap colorizer: stimulus and verdict
`timescale 1ns / 1ps

module tb;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // score
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // red, green, blue
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_idle;
    int          hold_cycles;

    score_heatmap_colorizer_core dut (.*);

    shc_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL score_heatmap_colorizer_core");
        $finish;
    end

    // receiver with random stalls and long hold-offs
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // leaves the item offered; the next call or drain takes it down
    task automatic send_score(input logic [23:0] sc);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= sc;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [23:0] pick_score(input logic [23:0] g, input logic [23:0] b);
        int m;
        m = $urandom_range(5);
        case (m)
            0: return 24'($urandom_range(g));
            1: return 24'(g + $urandom_range(b > g ? b - g : 0));
            2: return 24'(b + $urandom_range(16 * b));
            3: return 24'($urandom_range(3));
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [23:0] lv [7][2];
        logic [23:0] g;
        logic [23:0] b;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = shc_pkg::REG_GOOD_LEVEL;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        send_idle = 34;
        recv_idle = 88;
        hold_cycles = 0;
        lv = '{'{24'd65536, 24'd98304}, '{24'd1, 24'd1}, '{24'hffffff, 24'hffffff},
               '{24'd0, 24'd4000}, '{24'd90000, 24'd30000}, '{24'd5000, 24'd0},
               '{24'd300, 24'd700}};
        repeat (11) @(negedge clk);
        rst_n = 1;
        // directed at reset levels
        foreach (lv[i])
        begin
            g = lv[i][0];
            b = lv[i][1];
            if (i > 0)
            begin
                write_reg(shc_pkg::REG_GOOD_LEVEL, g);
                write_reg(shc_pkg::REG_BAD_LEVEL, b);
            end
            if (i == 0)
            begin
                send_score(24'd0);
                send_score(24'hffffff);
                send_score(24'(g - 1));
                send_score(g);
                send_score(24'(b - 1));
                send_score(b);
                send_score(24'h555555);
                send_score(24'haaaaaa);
                send_score(24'(13 * b));
            end
            if (i == 3)
                send_idle = 88;
            if (i == 3)
                recv_idle = 34;
            if (i == 5)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (i == 2)
                hold_cycles = 300;
            for (int k = 0; k < 150; k++)
                send_score(pick_score(g, b));
            send_score(g);
            send_score(b);
            drain();
        end
        if (fail_count == 0)
            $display("PASS score_heatmap_colorizer_core");
        else
            $display("FAIL score_heatmap_colorizer_core");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/shc_pkg.sv
design/score_heatmap_colorizer_core.sv
dv/shc_checker.sv
dv/tb.sv
